// ===== sv/fjb_pkg.sv =====
// Shared types, constants and helpers of the two-stream frame join barrier.
package fjb_pkg;

	localparam int TABLE_DEPTH  = 8;
	localparam int SLOTS        = TABLE_DEPTH + 1;
	localparam int IDX_W        = $clog2(SLOTS);
	localparam int CNT_W        = 4;
	localparam int HANDLE_WIDTH = 32;
	localparam int QDEPTH       = TABLE_DEPTH;
	localparam int QA_W         = $clog2(QDEPTH);

	localparam logic KIND_BEGIN  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic REC_STATUS = 1'b0;
	localparam logic REC_FRAME  = 1'b1;

	localparam int C_DUP  = 0;
	localparam int C_REGR = 1;
	localparam int C_INC  = 2;
	localparam int C_LATE = 3;

	localparam logic REG_MAX_PENDING = 1'b0;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_DUP      = 3'd1,
		ST_REGR     = 3'd2,
		ST_RETIRED  = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_FIN_OK   = 3'd5,
		ST_LATE     = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RSCAN, S_ALLOC, S_DSCAN, S_DPOP,
		S_LSCAN, S_LACT, S_FSCAN, S_FACT, S_EMIT
	} fsm_t;

	typedef struct packed {
		logic        kind;
		logic        side;
		logic [63:0] stamp;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		logic        record_type;
		logic [2:0]  status;
		logic [63:0] frame_stamp;
		logic [31:0] points_handle;
		logic [31:0] detections_handle;
		logic [31:0] completion_seq;
		logic [3:0]  pending_count;
		logic [31:0] duplicate_drops;
		logic [31:0] regressive_drops;
		logic [31:0] incomplete_drops;
		logic [31:0] late_drops;
		logic        last;
	} out_item_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

endpackage

// ===== sv/fjb_cq.sv =====
// Completion queue: holds finished frames until the status item has gone out.
module fjb_cq (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [fjb_pkg::QA_W-1:0]  wr_addr,
	input  fjb_pkg::out_item_t        wr_data,
	input  logic [fjb_pkg::QA_W-1:0]  rd_addr,
	output fjb_pkg::out_item_t        rd_data
);
	import fjb_pkg::*;

	out_item_t mem [QDEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== sv/two_stream_frame_join_barrier.sv =====
// Top level of the two-stream frame join barrier: table sequencer, counters, config port.
//
//  channel   signals                          handshake
//  -------   -------------------------------  ---------------------------------
//  command   start, busy, item                taken when start && !busy
//  result    done, result                     done marks each item, no stall
//  config    psel penable pwrite paddr pwdata write on psel&&penable&&pwrite
//
// A begin takes a check, a retirement walk over the table and an allocate step,
// then drain passes (each a minimum search plus a pop), and for each eviction
// a victim search plus a drain pass; a finish takes a stamp lookup plus drain
// passes. Emission then sends the result items. A begin rejected at the check,
// a begin that repeats a pending one on its side and a late finish skip the
// drain passes and go straight to emission. The sequencer walks the table one
// slot per cycle, comparing stamps as it goes.
// Reset clears the table marks, stream marks, counters and max_pending (to 8)
// at once; no clearing pass is needed. The receiver cannot stall: each result
// item appears for exactly one cycle with done high, the status item first.
module two_stream_frame_join_barrier (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fjb_pkg::in_item_t  item,
	output logic               done,
	output fjb_pkg::out_item_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import fjb_pkg::*;

	fsm_t state_q, state_d;

	// pending frame table
	logic [SLOTS-1:0]        valid_q;
	logic [63:0]             stamp_q  [SLOTS];
	logic [1:0]              begun_q  [SLOTS];
	logic [1:0]              fin_q    [SLOTS];
	logic [HANDLE_WIDTH-1:0] hnd_q    [SLOTS][2];

	// per-stream marks and counters
	logic        seen_v_q [2];
	logic [63:0] seen_s_q [2];
	logic        ret_v_q  [2];
	logic [63:0] ret_s_q  [2];
	logic [31:0] cnt_q    [4];
	logic [31:0] seq_q;
	logic [3:0]  maxp_q;
	logic [CNT_W-1:0] pend_q;

	// sequencer working registers
	in_item_t          cur_q;
	logic [IDX_W-1:0]  i_q;
	logic              match_q;
	logic [IDX_W-1:0]  e_q;
	logic              ffound_q;
	logic [IDX_W-1:0]  free_q;
	logic              found_q;
	logic [IDX_W-1:0]  min_q;
	logic [63:0]       min_stamp_q;
	logic [CNT_W-1:0]  qcnt_q;
	logic [CNT_W-1:0]  emit_q;
	status_t           status_q;

	logic        last_slot;
	logic        s;
	logic [3:0]  lim;
	logic        chk_dup, chk_regr, chk_ret;
	logic [IDX_W-1:0] eidx;
	logic        alloc_dup;
	logic        take;
	logic        lcand;
	logic        fin_ok;
	logic        rretire;
	logic [1:0]  sbit;
	logic [1:0]  rb_begun;
	out_item_t   q_wdata, q_rdata, stat_rec, emit_rec;
	logic        q_we;

	fjb_cq u_cq (
		.clk     (clk),
		.wr_en   (q_we),
		.wr_addr (qcnt_q[QA_W-1:0]),
		.wr_data (q_wdata),
		.rd_addr (emit_q[QA_W-1:0]),
		.rd_data (q_rdata)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_PENDING) ? {28'd0, maxp_q} : 32'd0;
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		s         = cur_q.side;
		sbit      = s ? 2'b10 : 2'b01;
		last_slot = (i_q == IDX_W'(SLOTS - 1));
		if (maxp_q == 4'd0) begin
			lim = 4'd1;
		end else if (maxp_q > 4'(TABLE_DEPTH)) begin
			lim = 4'(TABLE_DEPTH);
		end else begin
			lim = maxp_q;
		end
		chk_dup   = seen_v_q[s] && (cur_q.stamp == seen_s_q[s]);
		chk_regr  = seen_v_q[s] && (cur_q.stamp < seen_s_q[s]);
		chk_ret   = ret_v_q[s] && (cur_q.stamp <= ret_s_q[s]);
		rretire   = valid_q[i_q] && (stamp_q[i_q] < cur_q.stamp) && !begun_q[i_q][s];
		eidx      = match_q ? e_q : free_q;
		alloc_dup = match_q && begun_q[e_q][s];
		take      = found_q && (fin_q[min_q] == 2'b11);
		lcand     = valid_q[i_q] && ((begun_q[i_q] & ~fin_q[i_q]) == 2'b00);
		fin_ok    = match_q && begun_q[e_q][s] && !fin_q[e_q][s];
		rb_begun  = begun_q[e_q] & ~sbit;
		q_we      = (state_q == S_DPOP) && take;

		q_wdata.record_type       = REC_FRAME;
		q_wdata.status            = ST_ACCEPTED;
		q_wdata.frame_stamp       = stamp_q[min_q];
		q_wdata.points_handle     = hnd_q[min_q][0];
		q_wdata.detections_handle = hnd_q[min_q][1];
		q_wdata.completion_seq    = seq_q;
		q_wdata.pending_count     = pend_q - 4'd1;
		q_wdata.duplicate_drops   = cnt_q[C_DUP];
		q_wdata.regressive_drops  = cnt_q[C_REGR];
		q_wdata.incomplete_drops  = cnt_q[C_INC];
		q_wdata.late_drops        = cnt_q[C_LATE];
		q_wdata.last              = 1'b0;

		stat_rec.record_type       = REC_STATUS;
		stat_rec.status            = status_q;
		stat_rec.frame_stamp       = cur_q.stamp;
		stat_rec.points_handle     = '0;
		stat_rec.detections_handle = '0;
		stat_rec.completion_seq    = '0;
		stat_rec.pending_count     = pend_q;
		stat_rec.duplicate_drops   = cnt_q[C_DUP];
		stat_rec.regressive_drops  = cnt_q[C_REGR];
		stat_rec.incomplete_drops  = cnt_q[C_INC];
		stat_rec.late_drops        = cnt_q[C_LATE];
		stat_rec.last              = (qcnt_q == '0);

		// queued completion, marked last when it is the final one
		emit_rec      = q_rdata;
		emit_rec.last = (emit_q == qcnt_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (item.kind == KIND_FINISH) ? S_FSCAN : S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = (chk_dup || chk_regr || chk_ret) ? S_EMIT : S_RSCAN;
			end
			S_RSCAN: if (last_slot) state_d = S_ALLOC;
			S_ALLOC: state_d = alloc_dup ? S_EMIT : S_DSCAN;
			S_DSCAN: if (last_slot) state_d = S_DPOP;
			S_DPOP: begin
				if (take) begin
					state_d = S_DSCAN;
				end else if (cur_q.kind == KIND_BEGIN && pend_q > lim) begin
					state_d = S_LSCAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_LSCAN: if (last_slot) state_d = S_LACT;
			S_LACT:  state_d = found_q ? S_DSCAN : S_EMIT;
			S_FSCAN: if (last_slot) state_d = S_FACT;
			S_FACT:  state_d = fin_ok ? S_DSCAN : S_EMIT;
			S_EMIT:  if (emit_q == qcnt_q) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			for (int k = 0; k < SLOTS; k++) begin
				begun_q[k] <= 2'b00;
				fin_q[k]   <= 2'b00;
			end
			for (int k = 0; k < 2; k++) begin
				seen_v_q[k] <= 1'b0;
				seen_s_q[k] <= '0;
				ret_v_q[k]  <= 1'b0;
				ret_s_q[k]  <= '0;
			end
			for (int k = 0; k < 4; k++) cnt_q[k] <= '0;
			seq_q    <= '0;
			maxp_q   <= 4'd8;
			pend_q   <= '0;
			qcnt_q   <= '0;
			emit_q   <= '0;
			match_q  <= 1'b0;
			ffound_q <= 1'b0;
			found_q  <= 1'b0;
			i_q      <= '0;
			done     <= 1'b0;
			result   <= '0;
		end else begin
			done <= 1'b0;
			if (psel && penable && pwrite && paddr[2] == REG_MAX_PENDING) begin
				maxp_q <= pwdata[3:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cur_q    <= item;
						i_q      <= '0;
						match_q  <= 1'b0;
						ffound_q <= 1'b0;
						qcnt_q   <= '0;
						emit_q   <= '0;
					end
				end
				S_CHECK: begin
					if (chk_dup) begin
						cnt_q[C_DUP] <= sat_inc(cnt_q[C_DUP]);
						status_q     <= ST_DUP;
					end else if (chk_regr) begin
						cnt_q[C_REGR] <= sat_inc(cnt_q[C_REGR]);
						status_q      <= ST_REGR;
					end else if (chk_ret) begin
						cnt_q[C_REGR] <= sat_inc(cnt_q[C_REGR]);
						status_q      <= ST_RETIRED;
					end else begin
						seen_v_q[s] <= 1'b1;
						seen_s_q[s] <= cur_q.stamp;
					end
				end
				S_RSCAN: begin
					// retire older frames never begun on this side
					if (rretire) begin
						for (int k = 0; k < 2; k++) begin
							if (!begun_q[i_q][k] &&
							    (!ret_v_q[k] || stamp_q[i_q] > ret_s_q[k])) begin
								ret_v_q[k] <= 1'b1;
								ret_s_q[k] <= stamp_q[i_q];
							end
						end
						valid_q[i_q] <= 1'b0;
						begun_q[i_q] <= 2'b00;
						fin_q[i_q]   <= 2'b00;
						pend_q       <= pend_q - CNT_W'(1);
						cnt_q[C_INC] <= sat_inc(cnt_q[C_INC]);
					end
					if (valid_q[i_q] && stamp_q[i_q] == cur_q.stamp) begin
						match_q <= 1'b1;
						e_q     <= i_q;
					end
					if (!ffound_q && (!valid_q[i_q] || rretire)) begin
						ffound_q <= 1'b1;
						free_q   <= i_q;
					end
					i_q <= last_slot ? '0 : i_q + IDX_W'(1);
				end
				S_ALLOC: begin
					if (alloc_dup) begin
						cnt_q[C_DUP] <= sat_inc(cnt_q[C_DUP]);
						status_q     <= ST_DUP;
					end else begin
						if (!match_q) begin
							valid_q[eidx] <= 1'b1;
							stamp_q[eidx] <= cur_q.stamp;
							fin_q[eidx]   <= 2'b00;
							hnd_q[eidx][0] <= '0;
							hnd_q[eidx][1] <= '0;
							begun_q[eidx] <= sbit;
							pend_q        <= pend_q + CNT_W'(1);
						end else begin
							begun_q[eidx] <= begun_q[eidx] | sbit;
						end
						e_q     <= eidx;
						i_q     <= '0;
						found_q <= 1'b0;
					end
				end
				S_DSCAN, S_LSCAN: begin
					// oldest valid frame, or oldest not in progress
					if ((state_q == S_DSCAN ? valid_q[i_q] : lcand) &&
					    (!found_q || stamp_q[i_q] < min_stamp_q)) begin
						found_q     <= 1'b1;
						min_q       <= i_q;
						min_stamp_q <= stamp_q[i_q];
					end
					i_q <= last_slot ? '0 : i_q + IDX_W'(1);
				end
				S_DPOP: begin
					found_q <= 1'b0;
					i_q     <= '0;
					if (take) begin
						valid_q[min_q] <= 1'b0;
						begun_q[min_q] <= 2'b00;
						fin_q[min_q]   <= 2'b00;
						pend_q         <= pend_q - CNT_W'(1);
						seq_q          <= sat_inc(seq_q);
						qcnt_q         <= qcnt_q + CNT_W'(1);
					end else if (cur_q.kind == KIND_FINISH) begin
						status_q <= ST_FIN_OK;
					end else if (!(pend_q > lim)) begin
						status_q <= ST_ACCEPTED;
					end
				end
				S_LACT: begin
					cnt_q[C_INC] <= sat_inc(cnt_q[C_INC]);
					found_q      <= 1'b0;
					i_q          <= '0;
					if (found_q) begin
						// evict the victim
						for (int k = 0; k < 2; k++) begin
							if (!begun_q[min_q][k] &&
							    (!ret_v_q[k] || stamp_q[min_q] > ret_s_q[k])) begin
								ret_v_q[k] <= 1'b1;
								ret_s_q[k] <= stamp_q[min_q];
							end
						end
						valid_q[min_q] <= 1'b0;
						begun_q[min_q] <= 2'b00;
						fin_q[min_q]   <= 2'b00;
						pend_q         <= pend_q - CNT_W'(1);
					end else begin
						// roll back this begin
						begun_q[e_q] <= rb_begun;
						if (rb_begun == 2'b00) begin
							valid_q[e_q] <= 1'b0;
							fin_q[e_q]   <= 2'b00;
							pend_q       <= pend_q - CNT_W'(1);
						end
						if (!ret_v_q[~s] || cur_q.stamp > ret_s_q[~s]) begin
							ret_v_q[~s] <= 1'b1;
							ret_s_q[~s] <= cur_q.stamp;
						end
						status_q <= ST_OVERFLOW;
					end
				end
				S_FSCAN: begin
					if (valid_q[i_q] && stamp_q[i_q] == cur_q.stamp) begin
						match_q <= 1'b1;
						e_q     <= i_q;
					end
					i_q <= last_slot ? '0 : i_q + IDX_W'(1);
				end
				S_FACT: begin
					found_q <= 1'b0;
					i_q     <= '0;
					if (fin_ok) begin
						hnd_q[e_q][s] <= cur_q.payload;
						fin_q[e_q]    <= fin_q[e_q] | sbit;
					end else begin
						cnt_q[C_LATE] <= sat_inc(cnt_q[C_LATE]);
						status_q      <= ST_LATE;
					end
				end
				S_EMIT: begin
					// status item first, then queued completions
					done   <= 1'b1;
					result <= (emit_q == '0) ? stat_rec : emit_rec;
					emit_q <= emit_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	a_pend_matches: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == CNT_W'($countones(valid_q)))
		else $error("pending count out of step with table");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |=> !done)
		else $error("result after final item");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= CNT_W'(QDEPTH))
		else $error("completion queue overrun");
	a_idle_fit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> pend_q <= CNT_W'(TABLE_DEPTH))
		else $error("table overfull at idle");

endmodule
